>>> rtl/core/vsmc_pkg.sv
// Shared types, constants and GF(2^8) helpers for the letter block cipher.
package vsmc_pkg;

   // Block geometry
   localparam int BLOCK_BYTES = 16;
   localparam int BLOCK_ROWS  = 4;
   localparam int BLOCK_COLS  = 4;
   localparam int FILL_W      = 5;
   localparam int BEAT_W      = 4;
   localparam int KEY_POS_W   = 4;

   // Key handling
   localparam int KEY_LENGTH  = 16;
   localparam int KEY_REG_W   = 64;
   localparam int KEY_CHAR_W  = 7;

   // Letter handling
   localparam logic [7:0] CHAR_A      = 8'd65;
   localparam logic [7:0] CHAR_Z      = 8'd90;
   localparam logic [7:0] ALPHA_SIZE  = 8'd26;
   localparam logic [7:0] PAD_CHAR    = 8'd65;
   localparam logic [7:0] PARITY_MASK = 8'h80;
   localparam logic [7:0] GF_REDUCE   = 8'd27;

   // Configuration register indexes
   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   // First row of the circulant mixing matrix
   localparam logic [1:0] MIX_ROW [BLOCK_COLS] = '{2'd2, 2'd3, 2'd1, 2'd1};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_DRAIN
   } vsmc_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // take the input beat into the block
      logic mix;     // compute the mixed block into the output buffer
      logic shift;   // advance the output buffer by one byte
   } vsmc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic flush;   // the current input beat completes a block
   } vsmc_status_type;

   // Multiply by x in GF(2^8), polynomial 0x11B
   function automatic logic [7:0] gf_double(input logic [7:0] b);
      gf_double = {b[6:0], 1'b0} ^ (b[7] ? GF_REDUCE : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] b, input logic [1:0] coef);
      case (coef)
         2'd1: gf_mul = b;
         2'd2: gf_mul = gf_double(b);
         2'd3: gf_mul = gf_double(b) ^ b;
         default: gf_mul = 8'h00;
      endcase
   endfunction

   // Set bit 7 where the byte has odd parity
   function automatic logic [7:0] parity_mark(input logic [7:0] v);
      parity_mark = v | ((^v) ? PARITY_MASK : 8'h00);
   endfunction

   // Remainder modulo the alphabet size for any byte value:
   // subtract 8, 4, 2 and 1 times the alphabet size where it fits
   function automatic logic [7:0] mod_alpha(input logic [7:0] v);
      logic [7:0] r;
      r = v;
      for (int i = 3; i >= 0; i--) begin
         if (r >= (ALPHA_SIZE << i)) begin
            r = r - (ALPHA_SIZE << i);
         end
      end
      mod_alpha = r;
   endfunction

endpackage

>>> rtl/core/vsmc_ctrl.sv
// Sequencer: input beat, block mix, sixteen output beats.
module vsmc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic                     rsp_tlast,
   input  vsmc_pkg::vsmc_status_type status,
   output vsmc_pkg::vsmc_cmd_type    cmd
);
   import vsmc_pkg::*;

   localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(BLOCK_BYTES - 1);

   vsmc_state_type    state_ff, state_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;

   // State and beat counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         beat_ff  <= '0;
      end else begin
         state_ff <= state_in;
         beat_ff  <= beat_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      beat_in    = beat_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.flush) begin
                  state_in = ST_MIX;
               end
            end
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            beat_in  = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = (beat_ff == BEAT_LAST);
            if (rsp_tready) begin
               cmd.shift = 1'b1;
               beat_in   = beat_ff + 1'b1;
               if (beat_ff == BEAT_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/vsmc_datapath.sv
// Key substitution, block store, row rotate, parity mark and column mix.
module vsmc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [vsmc_pkg::KEY_REG_W-1:0] csr_wdata,
   input  logic [7:0]                char_in,
   input  logic                      message_end,
   input  vsmc_pkg::vsmc_cmd_type    cmd,
   output vsmc_pkg::vsmc_status_type status,
   output logic [7:0]                cipher_byte,
   output logic                      message_last
);
   import vsmc_pkg::*;

   localparam logic [KEY_POS_W-1:0] KEY_POS_LAST = KEY_POS_W'(KEY_LENGTH - 1);
   localparam logic [FILL_W-1:0]    FILL_FULL    = FILL_W'(BLOCK_BYTES);

   logic [KEY_REG_W-1:0] key_low_ff, key_low_in;
   logic [KEY_REG_W-1:0] key_high_ff, key_high_in;
   logic [KEY_POS_W-1:0] key_pos_ff, key_pos_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 end_ff, end_in;
   logic [7:0]           store_ff [BLOCK_BYTES];
   logic [7:0]           store_in [BLOCK_BYTES];
   logic [7:0]           out_ff   [BLOCK_BYTES];
   logic [7:0]           out_in   [BLOCK_BYTES];

   logic                 is_letter;
   logic [KEY_REG_W-1:0] key_word;
   logic [KEY_CHAR_W-1:0] key_char;
   logic [7:0]           letter_sum;
   logic [7:0]           sub_char;
   logic [FILL_W-1:0]    fill_next;
   logic                 pad;
   logic [7:0]           marked [BLOCK_ROWS][BLOCK_COLS];
   logic [7:0]           mixed  [BLOCK_BYTES];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_pos_ff  <= '0;
         fill_ff     <= '0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         key_pos_ff  <= key_pos_in;
         fill_ff     <= fill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      end_ff   <= end_in;
      store_ff <= store_in;
      out_ff   <= out_in;
   end

   // Key register writes
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_in  = csr_wdata;
            CSR_KEY_HIGH: key_high_in = csr_wdata;
            default: begin
               key_low_in = key_low_ff;
            end
         endcase
      end
   end

   // Substitute the letter with the current key character (code plus key, mod 26)
   assign is_letter  = (char_in >= CHAR_A) && (char_in <= CHAR_Z);
   assign key_word   = key_pos_ff[KEY_POS_W-1] ? key_high_ff : key_low_ff;
   assign key_char   = key_word[{key_pos_ff[2:0], 3'b000} +: KEY_CHAR_W];
   assign letter_sum = char_in + {1'b0, key_char};
   assign sub_char   = mod_alpha(letter_sum) + CHAR_A;

   // Block completes when full or at message end with letters in it
   assign fill_next    = fill_ff + FILL_W'(is_letter);
   assign pad          = message_end && (fill_next != '0);
   assign status.flush = (is_letter && (fill_next == FILL_FULL)) || pad;

   // Load the beat: store letter, pad, advance key and fill
   always_comb begin
      store_in   = store_ff;
      key_pos_in = key_pos_ff;
      fill_in    = fill_ff;
      end_in     = end_ff;
      if (cmd.load) begin
         end_in = message_end;
         if (is_letter) begin
            store_in[fill_ff[BEAT_W-1:0]] = sub_char;
            key_pos_in = (key_pos_ff >= KEY_POS_LAST) ? '0 : key_pos_ff + 1'b1;
         end
         if (pad) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
               if (FILL_W'(k) >= fill_next) begin
                  store_in[k] = PAD_CHAR;
               end
            end
         end
         if (message_end) begin
            key_pos_in = '0;
         end
         fill_in = status.flush ? '0 : fill_next;
      end
   end

   // Rotate row r left by r and mark odd parity
   always_comb begin
      for (int r = 0; r < BLOCK_ROWS; r++) begin
         for (int c = 0; c < BLOCK_COLS; c++) begin
            marked[r][c] = parity_mark(store_ff[r * BLOCK_COLS + ((c + r) % BLOCK_COLS)]);
         end
      end
   end

   // Mix each column with the circulant matrix
   always_comb begin
      for (int r = 0; r < BLOCK_ROWS; r++) begin
         for (int c = 0; c < BLOCK_COLS; c++) begin
            mixed[r * BLOCK_COLS + c] = '0;
            for (int l = 0; l < BLOCK_ROWS; l++) begin
               mixed[r * BLOCK_COLS + c] = mixed[r * BLOCK_COLS + c]
                  ^ gf_mul(marked[l][c], MIX_ROW[(l - r + BLOCK_COLS) % BLOCK_COLS]);
            end
         end
      end
   end

   // Output buffer: capture the mixed block, then shift one byte per beat
   always_comb begin
      out_in = out_ff;
      if (cmd.mix) begin
         out_in = mixed;
      end else if (cmd.shift) begin
         for (int k = 0; k < BLOCK_BYTES - 1; k++) begin
            out_in[k] = out_ff[k + 1];
         end
      end
   end

   // Message end flag of the block being drained; qualified by the last beat in the top level
   assign cipher_byte  = out_ff[0];
   assign message_last = end_ff;

endmodule

>>> rtl/core/vigenere_shiftrows_mixcolumns_cipher.sv
// Top level of the letter block cipher: sequencer plus datapath.
//
//   channel  dir  handshake               payload
//   req      in   req_tvalid/req_tready   tdata[7:0] char_in, tlast message_end
//   rsp      out  rsp_tvalid/rsp_tready   tdata[7:0] cipher_byte, tlast block_last,
//                                         tuser message_last
//   csr      in   csr_we                  csr_index, csr_wdata (key register)
//
// A beat that completes no block leaves the sequencer idle and ready for the
// next beat. A beat that completes a block is loaded, then the block is mixed
// into the output buffer and sent as sixteen one-byte output beats.
// Input is held off while a block drains; output stalls simply hold it.
// Reset clears the key registers, key position and fill count.
module vigenere_shiftrows_mixcolumns_cipher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] char_in
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] cipher_byte
   output logic                          rsp_tlast,
   output logic                          rsp_tuser,   // [0] message_last
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [vsmc_pkg::KEY_REG_W-1:0] csr_wdata
);
   import vsmc_pkg::*;

   vsmc_cmd_type    cmd;
   vsmc_status_type status;
   logic            msg_flag;

   vsmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   vsmc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .char_in      (req_tdata),
      .message_end  (req_tlast),
      .cmd          (cmd),
      .status       (status),
      .cipher_byte  (rsp_tdata),
      .message_last (msg_flag)
   );

   // Flag message end on the last beat of the block only
   assign rsp_tuser = msg_flag & rsp_tlast;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the letter block cipher with its own block predictor.
module tb_top;
   import vsmc_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } plain_beat_t;

   typedef struct packed {
      logic [7:0] data;
      logic       blk_end;
      logic       msg_end;
   } cipher_beat_t;

   localparam int MIX_COEF [4] = '{2, 3, 1, 1};
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER_BEATS = 16;
   localparam int ITEMS_PER_KEY = 16;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // [7:0] char_in
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;        // [7:0] cipher_byte
   logic                 rsp_tlast;
   logic                 rsp_tuser;        // [0] message_last
   logic                 csr_we = 1'b0;
   logic                 csr_index = CSR_KEY_LOW;
   logic [KEY_REG_W-1:0] csr_wdata = '0;

   // Predictor state: key registers, key position, partial block
   logic [63:0]  key_lo = '0;
   logic [63:0]  key_hi = '0;
   logic [3:0]   key_idx = '0;
   logic [4:0]   fill_level = '0;
   logic [7:0]   plain_block [16];

   plain_beat_t  char_backlog [$];
   cipher_beat_t cipher_due [$];

   logic req_went = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   rsp_hold = 0;
   logic hold_done = 1'b0;
   int   mismatches = 0;
   int   beats_in = 0;
   int   letters_in = 0;
   int   beats_out = 0;
   int   blocks_due = 0;
   int   key_settings = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   vigenere_shiftrows_mixcolumns_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v >= CHAR_A && v <= CHAR_Z);
      return v;
   endfunction

   function automatic logic [7:0] gf_x2(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_REDUCE : 8'h00);
   endfunction

   function automatic logic [7:0] gf_scale(input logic [7:0] b, input int coef);
      case (coef)
         1: return b;
         2: return gf_x2(b);
         default: return gf_x2(b) ^ b;
      endcase
   endfunction

   // Substitute one beat into the block; on a flush, push the 16 mixed bytes
   task automatic encipher_char(input plain_beat_t beat);
      logic [7:0] kc;
      logic [7:0] v;
      logic [7:0] acc;
      logic [7:0] grid [4][4];
      logic       flush;
      int         sum;
      int         r, c, l, k;
      flush = 1'b0;
      if (beat.ch >= CHAR_A && beat.ch <= CHAR_Z) begin
         kc = key_idx[3] ? key_hi[8*key_idx[2:0] +: 8] : key_lo[8*key_idx[2:0] +: 8];
         sum = (int'(beat.ch) + int'(kc[6:0])) % 26 + int'(CHAR_A);
         plain_block[fill_level[3:0]] = sum[7:0];
         fill_level = fill_level + 5'd1;
         key_idx = key_idx + 4'd1;
         letters_in++;
         if (fill_level >= 5'd16) flush = 1'b1;
      end
      if (beat.fin) begin
         if (fill_level > 0) begin
            for (k = fill_level; k < 16; k++) plain_block[k] = PAD_CHAR;
            flush = 1'b1;
         end
         key_idx = '0;
      end
      if (flush) begin
         // rotate rows left and mark odd parity
         for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
               v = plain_block[r*4 + ((c + r) % 4)];
               if (^v) v[7] = 1'b1;
               grid[r][c] = v;
            end
         end
         // column mix, emitted row by row
         for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
               acc = '0;
               for (l = 0; l < 4; l++) acc ^= gf_scale(grid[l][c], MIX_COEF[(l - r + 4) % 4]);
               cipher_due.push_back(cipher_beat_t'{data: acc,
                                                   blk_end: (r == 3 && c == 3),
                                                   msg_end: (r == 3 && c == 3) && beat.fin});
            end
         end
         fill_level = '0;
         blocks_due++;
      end
   endtask

   // Drive the input channel from the backlog
   always @(negedge clock) begin
      plain_beat_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_went) begin
         if (req_went) req_gap = pick_gap();
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (char_backlog.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            nxt = char_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= nxt.ch;
            req_tlast <= nxt.fin;
         end
      end
   end

   // Drive rsp_tready: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && beats_out >= HOLD_AFTER_BEATS) begin
         hold_done = 1'b1;
         rsp_hold = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_tvalid) rsp_gap = pick_gap();
      end
   end

   // Predict on every input beat, check every output beat
   always @(posedge clock) begin
      cipher_beat_t want;
      req_went = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_went = 1'b1;
            beats_in++;
            encipher_char(plain_beat_t'{ch: req_tdata, fin: req_tlast});
         end
         if (rsp_tvalid && rsp_tready) begin
            beats_out++;
            if (cipher_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected output beat, actual data %02h last %b user %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = cipher_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  mismatches++;
                  $display("%0t: cipher_byte mismatch, expected %02h, actual %02h",
                           $time, want.data, rsp_tdata);
               end
               if (rsp_tlast !== want.blk_end) begin
                  mismatches++;
                  $display("%0t: block_last mismatch, expected %b, actual %b",
                           $time, want.blk_end, rsp_tlast);
               end
               if (rsp_tuser !== want.msg_end) begin
                  mismatches++;
                  $display("%0t: message_last mismatch, expected %b, actual %b",
                           $time, want.msg_end, rsp_tuser);
               end
            end
         end
      end
   end

   task automatic queue_char(input logic [7:0] ch, input logic fin);
      char_backlog.push_back(plain_beat_t'{ch: ch, fin: fin});
   endtask

   // Key register write; the block is idle whenever this is called
   task automatic set_key(input logic idx, input logic [63:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_KEY_LOW) key_lo = value;
      else key_hi = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_keys(input logic [63:0] lo, input logic [63:0] hi);
      set_key(CSR_KEY_LOW, lo);
      set_key(CSR_KEY_HIGH, hi);
      key_settings++;
   endtask

   // Hold until every beat is sent and every byte is back, then let the block settle
   task automatic settle();
      while (char_backlog.size() != 0 || req_tvalid || cipher_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random message: letters with some noise, ended by a flagged beat
   task automatic gen_message(output int counted);
      int letters, k, r, end_mode;
      counted = 0;
      r = $urandom_range(0, 99);
      if (r < 5) letters = 0;
      else if (r < 25) letters = 16;
      else if (r < 40) letters = $urandom_range(17, 40);
      else letters = $urandom_range(1, 15);
      end_mode = $urandom_range(0, 99);
      for (k = 0; k < letters; k++) begin
         if ($urandom_range(0, 4) == 0) queue_char(noise_char(), 1'b0);
         queue_char(8'($urandom_range(65, 90)), (k == letters - 1) && end_mode < 50);
         counted++;
      end
      if (letters == 0 || end_mode >= 50) begin
         queue_char(noise_char(), 1'b1);
         counted++;
      end
   endtask

   initial begin
      int ph, k, sent, got;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: empty end, single padded letter, dropped bytes, full block
      load_keys('0, '0);
      queue_char(8'h00, 1'b1);
      queue_char(CHAR_A, 1'b1);
      queue_char(CHAR_Z, 1'b0);
      queue_char(8'd64, 1'b0);
      queue_char(8'd91, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(8'h80, 1'b0);
      queue_char(8'd77, 1'b0);
      queue_char(8'h20, 1'b1);
      queue_char(8'h7F, 1'b1);
      for (k = 0; k < 16; k++) queue_char(CHAR_A + 8'(k), 1'b0);
      queue_char(8'h00, 1'b1);
      settle();

      // random messages under several key settings
      for (ph = 1; ph <= 4; ph++) begin
         case (ph)
            1: load_keys('1, '1);
            2: load_keys({$urandom, $urandom}, {$urandom, $urandom});
            3: load_keys({$urandom, $urandom}, 64'h7F00_7F00_7F00_7F00);
            default: load_keys('0, '1);
         endcase
         sent = 0;
         while (sent < ITEMS_PER_KEY) begin
            gen_message(got);
            sent += got;
         end
         settle();
      end

      $display("Coverage: %0d input beats (%0d letters) under %0d key settings,",
               beats_in, letters_in, key_settings);
      $display("          %0d cipher bytes in %0d blocks checked.", beats_out, blocks_due);
      if (cipher_due.size() != 0)
         $display("%0t: %0d expected bytes never arrived", $time, cipher_due.size());
      if (mismatches == 0 && cipher_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(4_000_000);
      $display("%0t: timeout with %0d bytes outstanding", $time, cipher_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
